[hdl/dsfp_pkg.sv]
// Shared types, codes and constants of the sparse forward projection unit.
package dsfp_pkg;

   // default sizes
   localparam int DEF_MAX_SAMPLES      = 32;
   localparam int DEF_NUM_ORIENT       = 4096;
   localparam int DEF_NUM_VOXELS       = 1024;
   localparam int DEF_MAX_COMPARTMENTS = 4;

   // datapath widths
   localparam int WORD_W = 16;
   localparam int COEF_W = 32;
   localparam int PROD_W = 48;
   localparam int SUM_W  = 50;
   localparam int RND_W  = 35;
   localparam int LP_W   = 52;
   localparam int ADD_W  = 44;
   localparam int ACC_W  = 48;
   localparam int SMP_IW = 8;

   // item kinds
   localparam logic [2:0] KIND_LOAD  = 3'd0;
   localparam logic [2:0] KIND_INTRA = 3'd1;
   localparam logic [2:0] KIND_EXTRA = 3'd2;
   localparam logic [2:0] KIND_ISO   = 3'd3;
   localparam logic [2:0] KIND_READ  = 3'd4;

   // dictionary select
   localparam logic [1:0] TSEL_INTRA = 2'd0;
   localparam logic [1:0] TSEL_EXTRA = 2'd1;
   localparam logic [1:0] TSEL_ISO   = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_SAMPLES = 2'd0;
   localparam logic [1:0] CSR_INTRA   = 2'd1;
   localparam logic [1:0] CSR_EXTRA   = 2'd2;
   localparam logic [1:0] CSR_ISO     = 2'd3;

   typedef struct packed {
      logic [2:0]         kind;
      logic [1:0]         table_sel;
      logic [1:0]         compartment;
      logic [11:0]        orientation;
      logic [4:0]         sample;
      logic [9:0]         voxel;
      logic [15:0]        seg_length;
      logic signed [31:0] coef0;
      logic signed [31:0] coef1;
      logic signed [31:0] coef2;
      logic signed [31:0] coef3;
      logic               clear_after_read;
   } req_type;

   typedef struct packed {
      logic signed [47:0] acc_value;
      logic [9:0]         acc_voxel;
      logic [4:0]         acc_sample;
   } rsp_type;

   // dictionary read request, one sample
   typedef struct packed {
      logic              vld;
      logic [1:0]        tsel;
      logic [11:0]       orient;
      logic [SMP_IW-1:0] smp;
   } dict_rd_type;

   // accumulate pipeline status toward the accumulator store
   typedef struct packed {
      logic                    busy;
      logic                    vld4;
      logic [SMP_IW-1:0]       smp4;
      logic                    vld5;
      logic [SMP_IW-1:0]       smp5;
      logic signed [ADD_W-1:0] add;
   } mac_out_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   function automatic logic [2:0] clamp_count(input logic [2:0] c, input int mc);
      logic [2:0] r;
      r = (int'(c) > mc) ? 3'(mc) : c;
      return r;
   endfunction

endpackage

[hdl/dsfp_ram.sv]
// Generic single write port, single read port RAM with registered read.
module dsfp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

[hdl/dsfp_dict.sv]
// Dictionary stores, one bank per compartment for each of the three tables.
module dsfp_dict
   import dsfp_pkg::*;
#(
   parameter int MAX_SAMPLES      = DEF_MAX_SAMPLES,
   parameter int NUM_ORIENT       = DEF_NUM_ORIENT,
   parameter int MAX_COMPARTMENTS = DEF_MAX_COMPARTMENTS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     ld_en,
   input  req_type                                  ld_req,
   input  dict_rd_type                              rd,
   output logic                                     rd_vld,
   output logic [SMP_IW-1:0]                        rd_smp,
   output logic [MAX_COMPARTMENTS-1:0][WORD_W-1:0]  rd_word
);
   localparam int DDEPTH = NUM_ORIENT * MAX_SAMPLES;
   localparam int DAW    = DDEPTH > 1 ? $clog2(DDEPTH) : 1;
   localparam int IAW    = MAX_SAMPLES > 1 ? $clog2(MAX_SAMPLES) : 1;

   logic              ld_ok, ld_big;
   logic [DAW-1:0]    ld_addr, rd_addr;
   logic [IAW-1:0]    ld_iaddr, rd_iaddr;
   logic [1:0]        tsel_ff;
   logic              vld_ff;
   logic [SMP_IW-1:0] smp_ff;
   logic [MAX_COMPARTMENTS-1:0][WORD_W-1:0] w_intra, w_extra, w_iso;

   always_comb begin
      ld_ok  = ld_en && (int'(ld_req.compartment) < MAX_COMPARTMENTS)
               && (int'(ld_req.sample) < MAX_SAMPLES);
      ld_big = (int'(ld_req.orientation) < NUM_ORIENT);
      ld_addr  = DAW'(32'(ld_req.orientation) * MAX_SAMPLES + 32'(ld_req.sample));
      ld_iaddr = IAW'(ld_req.sample);
      rd_addr  = DAW'(32'(rd.orient) * MAX_SAMPLES + 32'(rd.smp));
      rd_iaddr = IAW'(rd.smp);
   end

   for (genvar c = 0; c < MAX_COMPARTMENTS; c++) begin : g_bank
      logic hit;
      assign hit = ld_ok && (int'(ld_req.compartment) == c);

      dsfp_ram #(.WIDTH(WORD_W), .DEPTH(DDEPTH)) u_intra (
         .clock(clock), .we(hit && ld_big && ld_req.table_sel == TSEL_INTRA),
         .waddr(ld_addr), .wdata(ld_req.coef0[WORD_W-1:0]),
         .raddr(rd_addr), .rdata(w_intra[c]));

      dsfp_ram #(.WIDTH(WORD_W), .DEPTH(DDEPTH)) u_extra (
         .clock(clock), .we(hit && ld_big && ld_req.table_sel == TSEL_EXTRA),
         .waddr(ld_addr), .wdata(ld_req.coef0[WORD_W-1:0]),
         .raddr(rd_addr), .rdata(w_extra[c]));

      dsfp_ram #(.WIDTH(WORD_W), .DEPTH(MAX_SAMPLES)) u_iso (
         .clock(clock), .we(hit && ld_req.table_sel == TSEL_ISO),
         .waddr(ld_iaddr), .wdata(ld_req.coef0[WORD_W-1:0]),
         .raddr(rd_iaddr), .rdata(w_iso[c]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= rd.vld;
      end
      tsel_ff <= rd.tsel;
      smp_ff  <= rd.smp;
   end

   always_comb begin
      rd_vld = vld_ff;
      rd_smp = smp_ff;
      unique case (tsel_ff)
         TSEL_INTRA: rd_word = w_intra;
         TSEL_EXTRA: rd_word = w_extra;
         default:    rd_word = w_iso;
      endcase
   end
endmodule

[hdl/dsfp_mac.sv]
// Per-sample product, sum, rounding and length weighting pipeline.
module dsfp_mac
   import dsfp_pkg::*;
#(
   parameter int MAX_COMPARTMENTS = DEF_MAX_COMPARTMENTS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_vld,
   input  logic [SMP_IW-1:0]                       in_smp,
   input  logic [MAX_COMPARTMENTS-1:0][WORD_W-1:0] words,
   input  logic [MAX_COMPARTMENTS-1:0][COEF_W-1:0] coefs,
   input  logic                                    is_intra,
   input  logic [15:0]                             seg_len,
   output mac_out_type                             mo
);
   localparam logic signed [SUM_W-1:0] HALF15 = SUM_W'(16384);
   localparam logic signed [LP_W-1:0]  HALF8  = LP_W'(128);

   logic signed [PROD_W-1:0] p_in [MAX_COMPARTMENTS];
   logic signed [PROD_W-1:0] p_ff [MAX_COMPARTMENTS];
   logic signed [SUM_W-1:0]  sum, sum_r;
   logic signed [RND_W-1:0]  a_in, a_ff;
   logic signed [LP_W-1:0]   m_in, m_ff, m_r;
   logic signed [ADD_W-1:0]  d_in, d_ff;
   logic                     v2_ff, v3_ff, v4_ff, v5_ff;
   logic [SMP_IW-1:0]        s2_ff, s3_ff, s4_ff, s5_ff;

   always_comb begin
      for (int i = 0; i < MAX_COMPARTMENTS; i++) begin
         p_in[i] = $signed(coefs[i]) * $signed(words[i]);
      end
      sum = '0;
      for (int i = 0; i < MAX_COMPARTMENTS; i++) begin
         sum = sum + SUM_W'(p_ff[i]);
      end
      sum_r = sum + HALF15;
      a_in  = RND_W'(sum_r >>> 15);
      if (is_intra) begin
         m_in = a_ff * $signed({1'b0, seg_len});
      end else begin
         m_in = LP_W'(a_ff);
      end
      m_r = m_ff + HALF8;
      if (is_intra) begin
         d_in = ADD_W'(m_r >>> 8);
      end else begin
         d_in = ADD_W'(m_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v2_ff <= in_vld;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      for (int i = 0; i < MAX_COMPARTMENTS; i++) begin
         p_ff[i] <= p_in[i];
      end
      a_ff  <= a_in;
      m_ff  <= m_in;
      d_ff  <= d_in;
      s2_ff <= in_smp;
      s3_ff <= s2_ff;
      s4_ff <= s3_ff;
      s5_ff <= s4_ff;
   end

   always_comb begin
      mo.busy = in_vld | v2_ff | v3_ff | v4_ff | v5_ff;
      mo.vld4 = v4_ff;
      mo.smp4 = s4_ff;
      mo.vld5 = v5_ff;
      mo.smp5 = s5_ff;
      mo.add  = d_ff;
   end
endmodule

[hdl/dictionary_sparse_forward_projection_unit.sv]
// Top level of the dictionary-driven sparse forward projection unit.
//
// Usage:
//  - req channel (req_valid/req_stall/req_data) takes loads, segments and
//    accumulator reads; rsp channel returns one transfer per read item.
//  - csr port (csr_we/csr_index/csr_wdata) writes samples in use and the
//    three compartment counts; write only while the unit is idle.
//  - A load writes one dictionary word.
//  - A segment reads all compartment banks of one sample per cycle, then
//    drains the pipeline (dictionary read, product, sum, length weight,
//    round, accumulator read-modify-write) before the next item is taken.
//    A segment with nothing to add is taken and dropped.
//  - A read answers through the accumulator read and rsp_ff; a second read
//    waits until the first result has been taken, other items do not.
//  - Reset clears the 32768-entry accumulator store one entry per cycle;
//    req_stall stays high meanwhile.
//  - A stalled result holds in the output register.
module dictionary_sparse_forward_projection_unit
   import dsfp_pkg::*;
#(
   parameter int MAX_SAMPLES      = DEF_MAX_SAMPLES,
   parameter int NUM_ORIENT       = DEF_NUM_ORIENT,
   parameter int NUM_VOXELS       = DEF_NUM_VOXELS,
   parameter int MAX_COMPARTMENTS = DEF_MAX_COMPARTMENTS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [5:0] csr_wdata
);
   localparam int ACC_DEPTH = NUM_VOXELS * MAX_SAMPLES;
   localparam int AAW = ACC_DEPTH > 1 ? $clog2(ACC_DEPTH) : 1;
   localparam int NSW = $clog2(MAX_SAMPLES + 1);
   localparam int MC  = MAX_COMPARTMENTS;

   // configuration registers
   logic [5:0] sui_ff;
   logic [2:0] icnt_ff, ecnt_ff, scnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sui_ff  <= 6'd32;
         icnt_ff <= 3'd1;
         ecnt_ff <= 3'd1;
         scnt_ff <= 3'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLES: sui_ff  <= csr_wdata;
            CSR_INTRA:   icnt_ff <= csr_wdata[2:0];
            CSR_EXTRA:   ecnt_ff <= csr_wdata[2:0];
            CSR_ISO:     scnt_ff <= csr_wdata[2:0];
         endcase
      end
   end

   state_type state_ff, state_in;
   logic      req_acc, seg_go, is_seg, any_nz, rd_ok;
   logic [2:0] active;
   logic [NSW-1:0] ns;
   logic [3:0][COEF_W-1:0] rc;
   logic [MC-1:0][COEF_W-1:0] coef_in;

   // item held while a segment runs
   logic [MC-1:0][COEF_W-1:0] coef_ff;
   logic [AAW-1:0] vox_base_ff;
   logic [11:0]    orient_ff;
   logic [1:0]     tsel_ff;
   logic           intra_ff;
   logic [15:0]    len_ff;
   logic [NSW-1:0] ns_ff, cnt_ff;
   logic [AAW-1:0] clr_cnt_ff;

   // read path
   logic        rd_pend_ff, rd_ok_ff, rsp_vld_ff;
   logic [9:0]  rd_vox_ff;
   logic [4:0]  rd_smp_ff;
   rsp_type     rsp_ff;

   dict_rd_type  drd;
   logic         d_vld;
   logic [SMP_IW-1:0] d_smp;
   logic [MC-1:0][WORD_W-1:0] d_word;
   mac_out_type  mo;

   logic           acc_we;
   logic [AAW-1:0] acc_waddr, acc_raddr, req_addr;
   logic [ACC_W-1:0] acc_wdata, acc_rdata;
   logic signed [ACC_W:0] acc_sum;
   logic signed [ACC_W-1:0] acc_sat;

   // decode of the offered item
   always_comb begin
      rc = {req_data.coef3, req_data.coef2, req_data.coef1, req_data.coef0};
      unique case (req_data.kind)
         KIND_INTRA: active = clamp_count(icnt_ff, MC);
         KIND_EXTRA: active = clamp_count(ecnt_ff, MC);
         default:    active = clamp_count(scnt_ff, MC);
      endcase
      any_nz = 1'b0;
      for (int i = 0; i < MC; i++) begin
         coef_in[i] = (i < int'(active)) ? rc[i] : '0;
         if (coef_in[i] != '0) begin
            any_nz = 1'b1;
         end
      end
      ns = (int'(sui_ff) > MAX_SAMPLES) ? NSW'(MAX_SAMPLES) : NSW'(sui_ff);
      is_seg = (req_data.kind == KIND_INTRA) || (req_data.kind == KIND_EXTRA)
               || (req_data.kind == KIND_ISO);
      req_stall = (state_ff != ST_IDLE) ||
                  ((req_data.kind == KIND_READ) && (rsp_vld_ff || rd_pend_ff));
      req_acc = req_valid && !req_stall;
      seg_go  = req_acc && is_seg && any_nz && (ns != '0)
                && (int'(req_data.voxel) < NUM_VOXELS)
                && ((req_data.kind == KIND_ISO)
                    || (int'(req_data.orientation) < NUM_ORIENT));
      rd_ok   = (int'(req_data.voxel) < NUM_VOXELS)
                && (int'(req_data.sample) < MAX_SAMPLES);
      req_addr = AAW'(32'(req_data.voxel) * MAX_SAMPLES + 32'(req_data.sample));
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (int'(clr_cnt_ff) == ACC_DEPTH - 1) state_in = ST_IDLE;
         ST_IDLE:  if (seg_go) state_in = ST_RUN;
         ST_RUN:   if (cnt_ff == ns_ff - NSW'(1)) state_in = ST_DRAIN;
         ST_DRAIN: if (!d_vld && !mo.busy) state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         cnt_ff     <= '0;
      end else begin
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + AAW'(1);
         end
         if (seg_go) begin
            cnt_ff <= '0;
         end else if (state_ff == ST_RUN) begin
            cnt_ff <= cnt_ff + NSW'(1);
         end
      end
      if (seg_go) begin
         coef_ff     <= coef_in;
         vox_base_ff <= AAW'(32'(req_data.voxel) * MAX_SAMPLES);
         orient_ff   <= req_data.orientation;
         intra_ff    <= (req_data.kind == KIND_INTRA);
         len_ff      <= req_data.seg_length;
         ns_ff       <= ns;
         unique case (req_data.kind)
            KIND_INTRA: tsel_ff <= TSEL_INTRA;
            KIND_EXTRA: tsel_ff <= TSEL_EXTRA;
            default:    tsel_ff <= TSEL_ISO;
         endcase
      end
   end

   // one dictionary read per sample while running
   always_comb begin
      drd.vld    = (state_ff == ST_RUN);
      drd.tsel   = tsel_ff;
      drd.orient = orient_ff;
      drd.smp    = SMP_IW'(cnt_ff);
   end

   dsfp_dict #(
      .MAX_SAMPLES(MAX_SAMPLES), .NUM_ORIENT(NUM_ORIENT), .MAX_COMPARTMENTS(MC)
   ) u_dict (
      .clock(clock), .reset(reset),
      .ld_en(req_acc && req_data.kind == KIND_LOAD), .ld_req(req_data),
      .rd(drd), .rd_vld(d_vld), .rd_smp(d_smp), .rd_word(d_word));

   dsfp_mac #(.MAX_COMPARTMENTS(MC)) u_mac (
      .clock(clock), .reset(reset), .in_vld(d_vld), .in_smp(d_smp),
      .words(d_word), .coefs(coef_ff), .is_intra(intra_ff), .seg_len(len_ff),
      .mo(mo));

   // accumulator store: sweep clear, read-clear, or pipeline write-back
   always_comb begin
      acc_sum = (ACC_W + 1)'($signed(acc_rdata)) + (ACC_W + 1)'(mo.add);
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
         acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_sat = acc_sum[ACC_W-1:0];
      end
      acc_raddr = (state_ff == ST_IDLE) ? req_addr : vox_base_ff + AAW'(mo.smp4);
      priority if (state_ff == ST_CLEAR) begin
         acc_we    = 1'b1;
         acc_waddr = clr_cnt_ff;
         acc_wdata = '0;
      end else if (mo.vld5) begin
         acc_we    = 1'b1;
         acc_waddr = vox_base_ff + AAW'(mo.smp5);
         acc_wdata = acc_sat;
      end else begin
         acc_we    = req_acc && (req_data.kind == KIND_READ) && rd_ok
                     && req_data.clear_after_read;
         acc_waddr = req_addr;
         acc_wdata = '0;
      end
   end

   dsfp_ram #(.WIDTH(ACC_W), .DEPTH(ACC_DEPTH)) u_acc (
      .clock(clock), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
      .raddr(acc_raddr), .rdata(acc_rdata));

   // read result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         rd_pend_ff <= req_acc && (req_data.kind == KIND_READ);
         if (rd_pend_ff) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
      if (req_acc && req_data.kind == KIND_READ) begin
         rd_ok_ff  <= rd_ok;
         rd_vox_ff <= req_data.voxel;
         rd_smp_ff <= req_data.sample;
      end
      if (rd_pend_ff) begin
         rsp_ff.acc_value  <= rd_ok_ff ? $signed(acc_rdata) : '0;
         rsp_ff.acc_voxel  <= rd_vox_ff;
         rsp_ff.acc_sample <= rd_smp_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_acc_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> state_ff == ST_IDLE)
      else $error("transfer taken while busy");
   a_one_slot: assert property (@(posedge clock) disable iff (reset)
      !(rd_pend_ff && rsp_vld_ff))
      else $error("read result would overwrite a waiting result");
   a_no_wb_clear: assert property (@(posedge clock) disable iff (reset)
      mo.vld5 |-> (state_ff == ST_DRAIN || state_ff == ST_RUN))
      else $error("write-back outside a segment");
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> state_ff == ST_CLEAR)
      else $error("reset did not start the clearing sweep");
endmodule
